// ===== rtl/notification_slot_manager_unit_macros.svh =====
// Assertion macros for the notification slot manager.
// No dependencies.
`ifndef NOTIFICATION_SLOT_MANAGER_UNIT_MACROS_SVH
`define NOTIFICATION_SLOT_MANAGER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define NSM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NSM_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NSM_ASSERT(label, clk, rst, prop, msg)
`define NSM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/nsm_pkg.sv =====
// Package for the notification slot manager: types, codes and widths.
// No dependencies.
package nsm_pkg;
  localparam int SLOTS_DEFAULT = 8;
  localparam int IdW = 32;
  localparam int ExpW = 48;
  localparam int CfgW = 24;
  localparam logic [ExpW-1:0] EXP_MAX = '1;

  localparam logic [1:0] FUNC_POST = 2'd0;
  localparam logic [1:0] FUNC_CLOSE = 2'd1;
  localparam logic [1:0] FUNC_CLOSE_ALL = 2'd2;
  localparam logic [1:0] FUNC_TICK = 2'd3;

  localparam logic [1:0] REASON_EXPIRED = 2'd0;
  localparam logic [1:0] REASON_EVICTED = 2'd1;
  localparam logic [1:0] REASON_REQUEST = 2'd2;

  localparam logic CFG_LOW = 1'b0;
  localparam logic CFG_NORMAL = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [31:0] target_id;
    logic [1:0] urgency;
    logic [31:0] life_ms;
    logic [47:0] now_ms;
  } item_t;

  typedef struct packed {
    logic kind;
    logic [31:0] item_id;
    logic [1:0] close_reason;
    logic [31:0] next_expiry_ms;
    logic last;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the input beat
    logic scan_clr;  // start a scan: clear search results
    logic scan;      // examine slot at scan index
    logic close;     // remove found slot
    logic kill;      // remove slot at scan index
    logic write;     // write post into chosen slot
    logic compact;   // one compaction step
    logic idx_inc;
    logic idx_clr;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic idx_end;
    logic found;
    logic has_free;
    logic has_victim;
    logic cur_active;
    logic cur_expired;
    logic compact_done;
  } stat_t;
endpackage

// ===== rtl/nsm_datapath.sv =====
// Datapath of the notification slot manager: slot table, scan and compaction.
// Depends on nsm_pkg.
module nsm_datapath #(
  parameter int SLOTS = nsm_pkg::SLOTS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [nsm_pkg::CfgW-1:0] cfg_data,
  input  nsm_pkg::item_t item_in,
  input  nsm_pkg::cmd_t cmd,
  output nsm_pkg::stat_t stat,
  output logic [nsm_pkg::IdW-1:0] cur_id,
  output logic [nsm_pkg::IdW-1:0] victim_id,
  output logic [nsm_pkg::IdW-1:0] post_id,
  output logic [31:0] next_exp,
  output logic [1:0] func,
  output logic [nsm_pkg::IdW-1:0] rid
);
  import nsm_pkg::*;
  localparam int IW = $clog2(SLOTS);

  logic [CfgW-1:0] tlow, tnorm;
  item_t it;
  logic [SLOTS-1:0] active;
  logic [SLOTS-1:0] active_next;
  logic [IdW-1:0] ids [SLOTS];
  logic [1:0] urgs [SLOTS];
  logic [ExpW-1:0] exps [SLOTS];
  logic [IdW-1:0] id_counter;
  logic [IW:0] idx;
  logic [IW-1:0] ix;
  logic found, has_free, has_victim, victim_crit;
  logic [IW-1:0] found_ix, free_ix, victim_ix;
  logic [ExpW-1:0] best;
  logic [31:0] nexp;
  logic nexp_valid;
  logic [1:0] urg_sat;
  logic [IdW-1:0] new_cnt;
  logic [ExpW:0] sum;
  logic [ExpW-1:0] exp_val;
  logic [ExpW-1:0] dur;
  logic [ExpW:0] left;
  logic [IW-1:0] ins_ix;
  logic [IW-1:0] hole;
  logic hole_any;
  logic cur_cand1, cur_cand2;

  assign ix = idx[IW-1:0];
  assign urg_sat = (it.urgency > 2'd2) ? 2'd2 : it.urgency;
  assign new_cnt = (id_counter == '1) ? IdW'(1) : id_counter + IdW'(1);
  assign post_id = (it.target_id == '0) ? new_cnt : it.target_id;
  assign dur = it.life_ms[31] ? ExpW'((urg_sat == 2'd0) ? tlow : tnorm)
                               : ExpW'(it.life_ms);
  assign sum = {1'b0, it.now_ms} + {1'b0, dur};
  assign exp_val = (it.life_ms == '0) ? '0 : (sum[ExpW] ? EXP_MAX : sum[ExpW-1:0]);
  assign left = {1'b0, exps[ix]} - {1'b0, it.now_ms};
  assign ins_ix = found ? found_ix : (has_free ? free_ix : victim_ix);

  // Candidate for first-pass (non-critical) and critical victim selection.
  assign cur_cand1 = active[ix] && urgs[ix] < 2'd2 && exps[ix] != '0;
  assign cur_cand2 = active[ix] && exps[ix] != '0;

  // Lowest inactive slot that has an active slot above it.
  always_comb begin
    hole = '0;
    hole_any = 1'b0;
    for (int i = SLOTS - 2; i >= 0; i--) begin
      if (!active[i] && (active >> (i + 1)) != '0) begin
        hole = IW'(i);
        hole_any = 1'b1;
      end
    end
  end

  always_comb begin
    active_next = active;
    if (cmd.close) active_next[found_ix] = 1'b0;
    if (cmd.kill) active_next[ix] = 1'b0;
    if (cmd.write) active_next[ins_ix] = 1'b1;
    if (cmd.compact && hole_any) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        if (IW'(i) >= hole) active_next[i] = active[i+1];
      end
      active_next[SLOTS-1] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tlow <= CfgW'(5000);
      tnorm <= CfgW'(10000);
      active <= '0;
      id_counter <= '0;
      idx <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOW: tlow <= cfg_data;
          CFG_NORMAL: tnorm <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + 1'b1;
      active <= active_next;
      if (cmd.write && it.target_id == '0) id_counter <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) it <= item_in;
    if (cmd.write) begin
      ids[ins_ix] <= post_id;
      urgs[ins_ix] <= urg_sat;
      exps[ins_ix] <= exp_val;
    end else if (cmd.compact && hole_any) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        if (IW'(i) >= hole) begin
          ids[i] <= ids[i+1];
          urgs[i] <= urgs[i+1];
          exps[i] <= exps[i+1];
        end
      end
    end
    if (cmd.scan_clr) begin
      found <= 1'b0;
      has_free <= 1'b0;
      has_victim <= 1'b0;
      victim_crit <= 1'b0;
      nexp_valid <= 1'b0;
      nexp <= '1;
      best <= EXP_MAX;
      found_ix <= '0;
      free_ix <= '0;
      victim_ix <= '0;
    end else if (cmd.scan) begin
      if (!found && it.target_id != '0 && active[ix] && ids[ix] == it.target_id) begin
        found <= 1'b1;
        found_ix <= ix;
      end
      if (!has_free && !active[ix]) begin
        has_free <= 1'b1;
        free_ix <= ix;
      end
      // Non-critical candidates always beat critical ones.
      if (cur_cand1 && (!has_victim || victim_crit || exps[ix] < best)) begin
        has_victim <= 1'b1;
        victim_crit <= 1'b0;
        victim_ix <= ix;
        best <= exps[ix];
      end else if (cur_cand2 && !cur_cand1 && urg_sat == 2'd2 &&
                   (!has_victim || (victim_crit && exps[ix] < best))) begin
        has_victim <= 1'b1;
        victim_crit <= 1'b1;
        victim_ix <= ix;
        best <= exps[ix];
      end
      if (active[ix] && exps[ix] != '0 && !left[ExpW] && left != '0) begin
        nexp_valid <= 1'b1;
        if (left > (ExpW+1)'(32'h7FFFFFFF)) begin
          if (nexp > 32'h7FFFFFFF) nexp <= 32'h7FFFFFFF;
        end else if (left[31:0] < nexp) begin
          nexp <= left[31:0];
        end
      end
    end
  end

  assign stat.idx_end = (idx == (IW+1)'(SLOTS - 1));
  assign stat.found = found;
  assign stat.has_free = has_free;
  assign stat.has_victim = has_victim;
  assign stat.cur_active = active[ix];
  assign stat.cur_expired = active[ix] && exps[ix] != '0 && (left[ExpW] || left == '0);
  assign stat.compact_done = !hole_any;
  assign cur_id = ids[ix];
  assign victim_id = ids[victim_ix];
  assign next_exp = nexp_valid ? nexp : 32'hFFFFFFFF;
  assign func = it.func;
  assign rid = it.target_id;
endmodule

// ===== rtl/nsm_ctrl.sv =====
// Controller of the notification slot manager: sequences scans and results.
// Depends on nsm_pkg.
module nsm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output nsm_pkg::result_t res,
  output nsm_pkg::cmd_t cmd,
  input  nsm_pkg::stat_t stat,
  input  logic [nsm_pkg::IdW-1:0] cur_id,
  input  logic [nsm_pkg::IdW-1:0] victim_id,
  input  logic [nsm_pkg::IdW-1:0] post_id,
  input  logic [31:0] next_exp,
  input  logic [1:0] func,
  input  logic [nsm_pkg::IdW-1:0] rid
);
  import nsm_pkg::*;
  typedef enum logic [2:0] {
    IDLE, SCAN, DECIDE, WALK, COMPACT, DONE, WAIT
  } state_t;
  state_t state, state_next;
  logic out_valid_next;
  result_t res_next;
  // Id assigned by a post, held past the counter update.
  logic [IdW-1:0] post_id_q;
  logic hold;
  logic kill_now;

  assign hold = out_valid && !out_ready;
  assign in_ready = (state == IDLE) && !out_valid;
  assign kill_now = (func == FUNC_CLOSE_ALL && stat.cur_active) ||
                    (func == FUNC_TICK && stat.cur_expired);

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = hold;
    res_next = res;
    case (state)
      IDLE: begin
        cmd.load = in_valid && in_ready;
        cmd.scan_clr = 1'b1;
        cmd.idx_clr = 1'b1;
        if (in_valid && in_ready) state_next = SCAN;
      end
      SCAN: begin
        cmd.scan = 1'b1;
        cmd.idx_inc = !stat.idx_end;
        if (stat.idx_end) state_next = DECIDE;
      end
      DECIDE: begin
        if (!hold) begin
          case (func)
            FUNC_POST: begin
              if (stat.found || stat.has_free) begin
                cmd.write = 1'b1;
                state_next = COMPACT;
              end else if (stat.has_victim) begin
                cmd.write = 1'b1;
                out_valid_next = 1'b1;
                res_next = '{kind: 1'b0, item_id: victim_id, close_reason: REASON_EVICTED,
                             next_expiry_ms: '0, last: 1'b0};
                state_next = COMPACT;
              end else begin
                out_valid_next = 1'b1;
                res_next = '{kind: 1'b1, item_id: '0, close_reason: '0,
                             next_expiry_ms: '0, last: 1'b1};
                state_next = WAIT;
              end
            end
            FUNC_CLOSE: begin
              cmd.close = stat.found;
              if (stat.found) begin
                out_valid_next = 1'b1;
                res_next = '{kind: 1'b0, item_id: rid, close_reason: REASON_REQUEST,
                             next_expiry_ms: '0, last: 1'b0};
              end
              state_next = COMPACT;
            end
            default: begin
              cmd.idx_clr = 1'b1;
              state_next = WALK;
            end
          endcase
        end
      end
      WALK: begin
        if (!hold) begin
          if (kill_now) begin
            cmd.kill = 1'b1;
            out_valid_next = 1'b1;
            res_next = '{kind: 1'b0, item_id: cur_id,
                         close_reason: (func == FUNC_TICK) ? REASON_EXPIRED : REASON_REQUEST,
                         next_expiry_ms: '0, last: 1'b0};
          end
          cmd.idx_inc = !stat.idx_end;
          if (stat.idx_end) state_next = COMPACT;
        end
      end
      COMPACT: begin
        cmd.compact = 1'b1;
        if (stat.compact_done) state_next = DONE;
      end
      DONE: begin
        if (!hold) begin
          out_valid_next = 1'b1;
          res_next = '{kind: 1'b1,
                       item_id: (func == FUNC_POST) ? post_id_q : '0,
                       close_reason: '0,
                       next_expiry_ms: (func == FUNC_TICK) ? next_exp : '0,
                       last: 1'b1};
          state_next = WAIT;
        end
      end
      WAIT: if (!hold) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      res <= '0;
      post_id_q <= '0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      res <= res_next;
      if (state == DECIDE && !hold) post_id_q <= post_id;
    end
  end
endmodule

// ===== rtl/notification_slot_manager_unit.sv =====
// Notification slot manager: one post, close, close-all or tick per input beat.
// With the receiver ready the done beat leaves after a scan of one slot per cycle, a removal walk
// of one slot per cycle (close-all and tick) and one compaction step per hole; the next input beat
// is taken only after the done beat has left. Receiver stalls hold the walk and the result beats.
// Reset (rst, synchronous) clears all slots, the id counter and restores the
// default timeouts of 5000 and 10000 ms. Depends on nsm_pkg, nsm_datapath, nsm_ctrl and the macros header.
`include "notification_slot_manager_unit_macros.svh"
module notification_slot_manager_unit #(
  parameter int SLOTS = nsm_pkg::SLOTS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [nsm_pkg::CfgW-1:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  // func[1:0], target_id[33:2], urgency[35:34], life_ms[67:36], now_ms[115:68]
  input  logic [119:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // item_id[31:0], close_reason[33:32], next_expiry_ms[65:34]
  output logic [71:0] m_tdata,
  // kind
  output logic m_tuser,
  output logic m_tlast
);
  import nsm_pkg::*;
  item_t item;
  cmd_t cmd;
  stat_t stat;
  result_t res;
  logic [IdW-1:0] cur_id, victim_id, post_id, rid;
  logic [31:0] next_exp;
  logic [1:0] func;

  assign item.func = s_tdata[1:0];
  assign item.target_id = s_tdata[33:2];
  assign item.urgency = s_tdata[35:34];
  assign item.life_ms = s_tdata[67:36];
  assign item.now_ms = s_tdata[115:68];

  nsm_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .item_in(item), .cmd, .stat,
    .cur_id, .victim_id, .post_id, .next_exp, .func, .rid
  );

  nsm_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .out_valid(m_tvalid),
    .out_ready(m_tready), .res, .cmd, .stat, .cur_id, .victim_id, .post_id,
    .next_exp, .func, .rid
  );

  assign m_tdata = {6'd0, res.next_expiry_ms, res.close_reason, res.item_id};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  `NSM_ASSERT(a_last_done, clk, rst, m_tvalid |-> (m_tlast == m_tuser), "last only on done")
  `NSM_ASSERT(a_no_take_busy, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "busy after take")
  `NSM_ASSERT_RST(a_rst_quiet, clk, rst |=> !m_tvalid, "output beat right after reset")
endmodule

// ===== sim/notification_slot_manager_unit_test.sv =====
// Self-checking bench for notification_slot_manager_unit: posts, closes, close-all and ticks.
// A scoreboard class predicts the closure events and done beats of each input beat.
// Depends on nsm_pkg and the RTL of the block.
`timescale 1ns / 1ps
module notification_slot_manager_unit_test;
  import nsm_pkg::*;

  localparam int NSLOT = SLOTS_DEFAULT;
  localparam int WATCHDOG = 20000;

  class slot_table_board;
    logic [23:0] lifetime_low;
    logic [23:0] lifetime_normal;
    logic        active [NSLOT];
    logic [31:0] ident [NSLOT];
    logic [1:0]  urg [NSLOT];
    logic [47:0] expiry [NSLOT];
    logic [31:0] next_id;
    result_t     pending [$];
    int          errors;
    int          checked;

    function new();
      lifetime_low = 24'd5000;
      lifetime_normal = 24'd10000;
      for (int i = 0; i < NSLOT; i++) begin
        active[i] = 1'b0;
        ident[i] = '0;
        urg[i] = '0;
        expiry[i] = '0;
      end
      next_id = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_lifetime(logic idx, logic [23:0] v);
      if (idx == CFG_LOW) lifetime_low = v;
      else lifetime_normal = v;
    endfunction

    function void push(logic k, logic [31:0] id, logic [1:0] rs, logic [31:0] nx, logic l);
      result_t r;
      r.kind = k;
      r.item_id = id;
      r.close_reason = rs;
      r.next_expiry_ms = nx;
      r.last = l;
      pending.push_back(r);
    endfunction

    function void squeeze();
      int k;
      k = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (active[i]) begin
          active[k] = 1'b1;
          ident[k] = ident[i];
          urg[k] = urg[i];
          expiry[k] = expiry[i];
          k++;
        end
      end
      for (int i = k; i < NSLOT; i++) active[i] = 1'b0;
    endfunction

    function int locate(logic [31:0] id);
      if (id == 0) return -1;
      for (int i = 0; i < NSLOT; i++)
        if (active[i] && ident[i] == id) return i;
      return -1;
    endfunction

    function logic [47:0] sat_add(logic [47:0] now, logic [31:0] d);
      logic [48:0] s;
      s = {1'b0, now} + {17'b0, d};
      return s[48] ? EXP_MAX : s[47:0];
    endfunction

    function int victim(logic [1:0] u);
      int sel;
      logic [48:0] best;
      sel = -1;
      best = {1'b1, 48'b0};
      for (int i = 0; i < NSLOT; i++)
        if (active[i] && urg[i] < 2 && expiry[i] != 0 && {1'b0, expiry[i]} < best) begin
          best = {1'b0, expiry[i]};
          sel = i;
        end
      if (sel < 0 && u >= 2)
        for (int i = 0; i < NSLOT; i++)
          if (active[i] && expiry[i] != 0 && {1'b0, expiry[i]} < best) begin
            best = {1'b0, expiry[i]};
            sel = i;
          end
      return sel;
    endfunction

    function void note_item(item_t it);
      logic [1:0] u;
      int s;
      logic [31:0] id;
      logic [47:0] e;
      longint nearest, left;
      bit changed;
      u = (it.urgency > 2) ? 2'd2 : it.urgency;
      case (it.func)
        FUNC_POST: begin
          s = locate(it.target_id);
          if (s < 0)
            for (int i = 0; i < NSLOT; i++)
              if (!active[i]) begin
                s = i;
                break;
              end
          if (s < 0) begin
            s = victim(u);
            if (s >= 0) begin
              active[s] = 1'b0;
              push(1'b0, ident[s], REASON_EVICTED, '0, 1'b0);
            end
          end
          if (s < 0) begin
            push(1'b1, '0, '0, '0, 1'b1);
          end else begin
            id = it.target_id;
            if (id == 0) begin
              next_id = next_id + 32'd1;
              if (next_id == 0) next_id = 32'd1;
              id = next_id;
            end
            if (it.life_ms[31])
              e = sat_add(it.now_ms, {8'b0, (u == 0) ? lifetime_low : lifetime_normal});
            else if (it.life_ms == 0) e = '0;
            else e = sat_add(it.now_ms, it.life_ms);
            active[s] = 1'b1;
            ident[s] = id;
            urg[s] = u;
            expiry[s] = e;
            squeeze();
            push(1'b1, id, '0, '0, 1'b1);
          end
        end
        FUNC_CLOSE: begin
          s = locate(it.target_id);
          if (s >= 0) begin
            active[s] = 1'b0;
            squeeze();
            push(1'b0, it.target_id, REASON_REQUEST, '0, 1'b0);
          end
          push(1'b1, '0, '0, '0, 1'b1);
        end
        FUNC_CLOSE_ALL: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (active[i]) push(1'b0, ident[i], REASON_REQUEST, '0, 1'b0);
            active[i] = 1'b0;
          end
          push(1'b1, '0, '0, '0, 1'b1);
        end
        default: begin
          nearest = -1;
          changed = 0;
          for (int i = 0; i < NSLOT; i++) begin
            if (!active[i] || expiry[i] == 0) continue;
            left = longint'({16'b0, expiry[i]}) - longint'({16'b0, it.now_ms});
            if (left <= 0) begin
              active[i] = 1'b0;
              changed = 1;
              push(1'b0, ident[i], REASON_EXPIRED, '0, 1'b0);
            end else begin
              if (left > 2147483647) left = 2147483647;
              if (nearest < 0 || left < nearest) nearest = left;
            end
          end
          if (changed) squeeze();
          push(1'b1, '0, '0, nearest[31:0], 1'b1);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind)
        $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
      if (got.item_id !== want.item_id)
        $display("%0t: item_id exp %0d got %0d", $time, want.item_id, got.item_id);
      if (got.close_reason !== want.close_reason)
        $display("%0t: reason exp %0d got %0d", $time, want.close_reason, got.close_reason);
      if (got.next_expiry_ms !== want.next_expiry_ms)
        $display("%0t: next exp %0d got %0d", $time, $signed(want.next_expiry_ms),
                 $signed(got.next_expiry_ms));
      if (got.last !== want.last)
        $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CfgW-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [119:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  int send_idle = 0;
  int recv_stall = 0;
  bit hold_recv = 0;
  int quiet = 0;
  int accepted_in = 0;
  logic [47:0] clock_ms = 48'd1000;
  logic [31:0] seen_ids [$];
  slot_table_board board;

  notification_slot_manager_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        result_t r;
        r.kind = m_tuser;
        r.item_id = m_tdata[31:0];
        r.close_reason = m_tdata[33:32];
        r.next_expiry_ms = m_tdata[65:34];
        r.last = m_tlast;
        board.check_result(r);
        if (r.kind == 1'b1 && r.item_id != 0) seen_ids.push_back(r.item_id);
      end
      m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("notification_slot_manager_unit_test: errors");
        $finish;
      end
    end
  end

  task automatic send_item(item_t it);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tdata <= {4'b0, it.now_ms, it.life_ms, it.urgency, it.target_id, it.func};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(it);
    accepted_in++;
  endtask

  task automatic stop_input();
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_lifetime(logic idx, logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    board.set_lifetime(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic item_t mk(logic [1:0] f, logic [31:0] rid, logic [1:0] u,
                               logic [31:0] t, logic [47:0] now);
    item_t it;
    it.func = f;
    it.target_id = rid;
    it.urgency = u;
    it.life_ms = t;
    it.now_ms = now;
    return it;
  endfunction

  function automatic logic [31:0] pick_id();
    if (seen_ids.size() == 0 || $urandom_range(9) < 2) return $urandom;
    return seen_ids[$urandom_range(seen_ids.size() - 1)];
  endfunction

  function automatic item_t random_item();
    logic [31:0] t;
    int r;
    r = $urandom_range(99);
    clock_ms = clock_ms + 48'($urandom_range(4000));
    case ($urandom_range(5))
      0: t = 32'hFFFF_FFFF;
      1: t = 32'h8000_0000 | $urandom;
      2: t = '0;
      3: t = $urandom >> 1;
      default: t = $urandom_range(20000, 1);
    endcase
    if (r < 55) return mk(FUNC_POST, ($urandom_range(2) == 0) ? pick_id() : 32'd0,
                          2'($urandom_range(3)), t, clock_ms);
    if (r < 72) return mk(FUNC_CLOSE, ($urandom_range(9) == 0) ? 32'd0 : pick_id(),
                          2'($urandom_range(3)), $urandom, clock_ms);
    if (r < 76) return mk(FUNC_CLOSE_ALL, $urandom, 2'($urandom_range(3)), $urandom,
                          clock_ms);
    if ($urandom_range(19) == 0) clock_ms = 48'({$urandom, $urandom} & EXP_MAX);
    return mk(FUNC_TICK, $urandom, 2'($urandom_range(3)), $urandom, clock_ms);
  endfunction

  task automatic run_random(int n, int idle, int stall);
    send_idle = idle;
    recv_stall = stall;
    repeat (n) send_item(random_item());
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: defaults, sticky, saturation, replace, eviction, refusal.
    send_item(mk(FUNC_TICK, 32'd0, 2'd0, 32'd0, 48'd0));
    send_item(mk(FUNC_POST, 32'd0, 2'd0, 32'hFFFF_FFFF, 48'd100));
    send_item(mk(FUNC_POST, 32'd0, 2'd1, 32'hFFFF_FFFF, 48'd100));
    send_item(mk(FUNC_POST, 32'd0, 2'd2, 32'd0, 48'd100));
    send_item(mk(FUNC_POST, 32'd0, 2'd3, 32'h7FFF_FFFF, EXP_MAX - 48'd5));
    send_item(mk(FUNC_POST, 32'hFFFF_FFFF, 2'd1, 32'd50, 48'd0));
    send_item(mk(FUNC_POST, 32'd2, 2'd0, 32'd7, 48'd200));
    send_item(mk(FUNC_POST, 32'd0, 2'd2, 32'd300, 48'd200));
    send_item(mk(FUNC_POST, 32'd0, 2'd2, 32'd400, 48'd200));
    send_item(mk(FUNC_POST, 32'd0, 2'd0, 32'd20, 48'd200));
    send_item(mk(FUNC_POST, 32'd0, 2'd0, 32'd20, 48'd200));
    send_item(mk(FUNC_POST, 32'd0, 2'd2, 32'd20, 48'd200));
    send_item(mk(FUNC_POST, 32'd0, 2'd0, 32'd1, 48'd0));
    send_item(mk(FUNC_TICK, 32'd0, 2'd0, 32'd0, 48'd210));
    send_item(mk(FUNC_CLOSE, 32'd0, 2'd0, 32'd0, 48'd0));
    send_item(mk(FUNC_CLOSE, 32'h1234_5678, 2'd0, 32'd0, 48'd0));
    send_item(mk(FUNC_CLOSE, 32'd3, 2'd0, 32'd0, 48'd0));
    send_item(mk(FUNC_TICK, 32'd0, 2'd0, 32'd0, EXP_MAX));
    send_item(mk(FUNC_CLOSE_ALL, 32'd0, 2'd0, 32'd0, 48'd0));
    stop_input();
    drain();

    // Extreme lifetimes at both ends of the register range.
    write_lifetime(CFG_LOW, 24'd0);
    write_lifetime(CFG_NORMAL, 24'hFF_FFFF);
    send_item(mk(FUNC_POST, 32'd0, 2'd0, 32'hFFFF_FFFF, 48'd0));
    send_item(mk(FUNC_POST, 32'd0, 2'd1, 32'hFFFF_FFFF, EXP_MAX));
    send_item(mk(FUNC_TICK, 32'd0, 2'd0, 32'd0, 48'd5));
    run_random(80, 0, 0);
    stop_input();
    drain();

    write_lifetime(CFG_LOW, 24'($urandom));
    write_lifetime(CFG_NORMAL, 24'($urandom));
    run_random(70, 62, 0);

    // Long receiver hold-off while the sender keeps offering beats.
    hold_recv = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_recv = 0;
      end
      begin
        run_random(10, 0, 0);
        stop_input();
      end
    join
    drain();

    write_lifetime(CFG_LOW, 24'hFF_FFFF);
    write_lifetime(CFG_NORMAL, 24'd1);
    run_random(70, 0, 62);
    stop_input();
    drain();

    write_lifetime(CFG_LOW, 24'd5000);
    write_lifetime(CFG_NORMAL, 24'd10000);
    run_random(70, 15, 15);
    run_random(50, 0, 0);
    stop_input();
    drain();

    $display("Covered %0d input beats and %0d output beats over idle, stall and hold-off phases",
             accepted_in, board.checked);
    $display("with lifetime registers at zero, full scale, random values and defaults.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("notification_slot_manager_unit_test: clean");
    end else begin
      $display("notification_slot_manager_unit_test: errors");
    end
    $finish;
  end
endmodule
